// ===== design/array_linked_list_engine_core_defines.svh =====
// Assertion macros shared by the checker files of the linked-list engine.
// No dependencies; included by bare file name where assertions are written.
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALLE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/alle_pkg.sv =====
// Shared types, sizes and helper functions of the linked-list engine.
// No dependencies; imported by every module of the engine but alle_ram.
package alle_pkg;

    localparam int DEPTH      = 256;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int LEN_W      = 8;
    localparam int CMP_W      = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic [IDX_W-1:0] HEAD_FREE = '0;
    localparam logic [IDX_W-1:0] HEAD_DATA = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FREE_NODE,
        ST_FREE_NEXT,
        ST_WALK,
        ST_DEL_NEXT,
        ST_DEL_FREE,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_DONE
    } state_t;

    // Link held by entry idx right after reset: the free chain runs 1 .. DEPTH-2,
    // every other entry ends a chain.
    function automatic logic [IDX_W-1:0] init_link(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] wide;
        wide = {1'b0, idx} + (IDX_W+1)'(1);
        if (wide < (IDX_W+1)'(DEPTH - 1)) begin
            return wide[IDX_W-1:0];
        end
        return '0;
    endfunction

endpackage

// ===== design/alle_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the link array of the linked-list engine.
module alle_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/array_linked_list_engine_core.sv =====
// Top level of the array-backed linked-list engine: sequencer and value store.
// Depends on alle_pkg and alle_ram (link array).
//
// The engine keeps an ordered list of signed 32-bit values in a fixed pool of
// DEPTH nodes. Each input transfer is an insert (tuser 0) or a delete (tuser 1)
// at a 1-based position, and each produces exactly one result transfer with an
// error flag and the list length afterwards. After reset the engine writes every
// entry of the link memory to build the free chain and accepts nothing in that
// time. An operation at position p then takes longer the larger p is, since the
// position is reached by following links through the single-read-port link
// memory, one read per cycle; an out-of-range operation, and an insert into a
// full store, end without the walk. A stalled result register adds its stall.
// One operation is in flight at a time, and a new one may be accepted while the
// previous result still waits in the output register.
module array_linked_list_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [alle_pkg::S_TDATA_W-1:0] s_tdata,  // position[7:0], value[39:8]
    input  logic                           s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [alle_pkg::M_TDATA_W-1:0] m_tdata   // status[0], length[8:1], zeros
);
    import alle_pkg::*;

    state_t                   state_reg, state_next;
    kind_t                    kind_reg, kind_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [VAL_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]         node_reg, node_next;
    logic [IDX_W-1:0]         link_a_reg, link_a_next;
    logic [IDX_W-1:0]         link_b_reg, link_b_next;
    logic [POS_W-1:0]         steps_reg, steps_next;
    logic [IDX_W-1:0]         count_reg, count_next;
    logic                     err_reg, err_next;
    logic [IDX_W-1:0]         init_idx_reg, init_idx_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_status_reg, out_status_next;
    logic [LEN_W-1:0]         out_len_reg, out_len_next;

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         rd_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         wr_data;
    logic                     val_we;

    logic [POS_W-1:0]         in_pos;
    logic [CMP_W-1:0]         in_pos_w;
    logic [CMP_W-1:0]         count_w;
    logic                     in_range;

    logic signed [VAL_W-1:0]  value_mem [DEPTH];

    alle_ram #(
        .WIDTH  (IDX_W),
        .ADDR_W (IDX_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Stored values are written on insert only; results never carry them.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[node_reg] <= value_reg;
        end
    end

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_pos_w = CMP_W'(in_pos);
    assign count_w  = CMP_W'(count_reg);

    always_comb begin
        if (in_pos == '0) begin
            in_range = 1'b0;
        end else if (kind_t'(s_tuser) == KIND_INSERT) begin
            in_range = (in_pos_w <= count_w + CMP_W'(1));
        end else begin
            in_range = (in_pos_w <= count_w);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_len_reg, out_status_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            init_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            init_idx_reg  <= init_idx_next;
            out_valid_reg <= out_valid_next;
        end
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        addr_reg       <= addr_next;
        node_reg       <= node_next;
        link_a_reg     <= link_a_next;
        link_b_reg     <= link_b_next;
        steps_reg      <= steps_next;
        err_reg        <= err_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        addr_next       = addr_reg;
        node_next       = node_reg;
        link_a_next     = link_a_reg;
        link_b_next     = link_b_reg;
        steps_next      = steps_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        init_idx_next   = init_idx_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        rd_addr         = HEAD_FREE;
        wr_en           = 1'b0;
        wr_addr         = init_idx_reg;
        wr_data         = init_link(init_idx_reg);
        val_we          = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                wr_en         = 1'b1;
                init_idx_next = init_idx_reg + IDX_W'(1);
                if (init_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = kind_t'(s_tuser);
                    pos_next   = in_pos;
                    value_next = s_tdata[POS_W +: VAL_W];
                    err_next   = 1'b0;
                    if (!in_range) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (kind_t'(s_tuser) == KIND_INSERT) begin
                        // The free head is read now and arrives in ST_FREE_NODE.
                        rd_addr    = HEAD_FREE;
                        state_next = ST_FREE_NODE;
                    end else begin
                        rd_addr    = HEAD_DATA;
                        addr_next  = HEAD_DATA;
                        steps_next = in_pos;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_FREE_NODE: begin
                if (rd_data == '0) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    node_next  = rd_data;
                    rd_addr    = rd_data;
                    state_next = ST_FREE_NEXT;
                end
            end
            ST_FREE_NEXT: begin
                link_a_next = rd_data;
                rd_addr     = HEAD_DATA;
                addr_next   = HEAD_DATA;
                steps_next  = pos_reg;
                state_next  = ST_WALK;
            end
            ST_WALK: begin
                // rd_data is the successor of addr_reg. On the last step addr_reg
                // is the predecessor of the target position.
                if (steps_reg == POS_W'(1)) begin
                    if (kind_reg == KIND_INSERT) begin
                        link_b_next = rd_data;
                        state_next  = ST_W1;
                    end else if (rd_data == '0) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        node_next  = rd_data;
                        rd_addr    = rd_data;
                        state_next = ST_DEL_NEXT;
                    end
                end else begin
                    addr_next  = rd_data;
                    rd_addr    = rd_data;
                    steps_next = steps_reg - POS_W'(1);
                end
            end
            ST_DEL_NEXT: begin
                link_a_next = rd_data;
                rd_addr     = HEAD_FREE;
                state_next  = ST_DEL_FREE;
            end
            ST_DEL_FREE: begin
                link_b_next = rd_data;
                state_next  = ST_W1;
            end
            ST_W1: begin
                wr_en      = 1'b1;
                wr_addr    = (kind_reg == KIND_INSERT) ? HEAD_FREE : addr_reg;
                wr_data    = link_a_reg;
                state_next = ST_W2;
            end
            ST_W2: begin
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_data    = link_b_reg;
                val_we     = (kind_reg == KIND_INSERT);
                state_next = ST_W3;
            end
            ST_W3: begin
                wr_en   = 1'b1;
                wr_data = node_reg;
                if (kind_reg == KIND_INSERT) begin
                    wr_addr    = addr_reg;
                    count_next = count_reg + IDX_W'(1);
                end else begin
                    wr_addr    = HEAD_FREE;
                    count_next = count_reg - IDX_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = err_reg;
                    out_len_next    = LEN_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/alle_checker.sv =====
// Port-level checker of the linked-list engine and its bind to the top level.
// Depends on alle_pkg and array_linked_list_engine_core_defines.svh.
`include "array_linked_list_engine_core_defines.svh"

module alle_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [alle_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [alle_pkg::M_TDATA_W-1:0] m_tdata
);
    import alle_pkg::*;

    logic             seen_reg;
    logic [LEN_W-1:0] last_len_reg;
    logic             out_xfer;
    logic [LEN_W-1:0] out_len;

    assign out_xfer = m_tvalid && m_tready;
    assign out_len  = m_tdata[LEN_W:1];

    // Length reported by the most recent result transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            last_len_reg <= '0;
        end else if (out_xfer) begin
            seen_reg     <= 1'b1;
            last_len_reg <= out_len;
        end
    end

    `ALLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ALLE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `ALLE_ASSERT_IMPL(a_len_bound, aclk, aresetn, m_tvalid, out_len <= LEN_W'(DEPTH - 2), "length exceeds node pool")
    `ALLE_ASSERT_IMPL(a_err_keeps_len, aclk, aresetn, out_xfer && m_tdata[0] && seen_reg, out_len == last_len_reg, "failed operation changed the length")

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (.*);

// ===== test/array_linked_list_engine_core_checker.sv =====
// Scoreboard for the linked-list engine: follows both stream channels, predicts every result.
// Depends on alle_pkg for sizes, the kind codes and the chain head indexes.
`timescale 1ns / 1ps

module array_linked_list_engine_core_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [alle_pkg::S_TDATA_W-1:0] s_tdata,  // position[7:0], value[39:8]
    input  logic                           s_tuser,  // kind
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [alle_pkg::M_TDATA_W-1:0] m_tdata,  // status[0], length[8:1], zeros
    output int                             fail_count,
    output int                             outstanding
);
    import alle_pkg::*;

    typedef struct packed {
        logic             status;
        logic [LEN_W-1:0] length;
    } list_outcome_t;

    // Shadow copy of the node pool. Only the links and the count decide a result.
    logic [IDX_W-1:0] link_mem [DEPTH];
    logic [VAL_W-1:0] value_mem [DEPTH];
    int               list_len;

    list_outcome_t    outcome_q [$];
    list_outcome_t    want;
    logic             got_status;
    logic [LEN_W-1:0] got_len;
    logic             op_status;
    int               mism = 0;
    int               i;

    // Applies one insert or delete to the shadow pool; returns 1 on error.
    function automatic logic list_update(input kind_t k, input logic [POS_W-1:0] pos,
                                         input logic [VAL_W-1:0] v);
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] pred;
        int               p;
        int               step;
        p = int'(pos);
        if (k == KIND_INSERT) begin
            if (p < 1 || p > list_len + 1) begin
                return 1'b1;
            end
            node = link_mem[HEAD_FREE];
            // A free chain that ends at once means every node is in use.
            if (node == '0) begin
                return 1'b1;
            end
            link_mem[HEAD_FREE] = link_mem[node];
            value_mem[node] = v;
            pred = HEAD_DATA;
            for (step = 1; step < p; step++) begin
                pred = link_mem[pred];
            end
            link_mem[node] = link_mem[pred];
            link_mem[pred] = node;
            list_len++;
            return 1'b0;
        end
        if (p < 1 || p > list_len) begin
            return 1'b1;
        end
        pred = HEAD_DATA;
        for (step = 1; step < p; step++) begin
            pred = link_mem[pred];
        end
        node = link_mem[pred];
        if (node == '0) begin
            return 1'b1;
        end
        link_mem[pred] = link_mem[node];
        link_mem[node] = link_mem[HEAD_FREE];
        link_mem[HEAD_FREE] = node;
        list_len--;
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            // Free chain runs 1 .. DEPTH-2; the data head and the last free node end chains.
            for (i = 0; i < DEPTH; i++) begin
                link_mem[i] = (i + 1 < DEPTH - 1) ? IDX_W'(i + 1) : '0;
                value_mem[i] = '0;
            end
            list_len = 0;
            outcome_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[0];
                got_len = m_tdata[LEN_W:1];
                if (outcome_q.size() == 0) begin
                    mism++;
                    $display("%0t: result transfer with nothing expected: status %0d length %0d",
                             $realtime, got_status, got_len);
                end else begin
                    want = outcome_q.pop_front();
                    if (got_status !== want.status) begin
                        mism++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got_status);
                    end
                    if (got_len !== want.length) begin
                        mism++;
                        $display("%0t: length expected %0d actual %0d",
                                 $realtime, want.length, got_len);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                op_status = list_update(kind_t'(s_tuser), s_tdata[POS_W-1:0],
                                        s_tdata[POS_W +: VAL_W]);
                outcome_q.push_back('{status: op_status, length: LEN_W'(list_len)});
            end
        end
        fail_count <= mism;
        outstanding <= outcome_q.size();
    end

endmodule

// ===== test/tb_array_linked_list_engine_core.sv =====
// Testbench top for the linked-list engine: clock, reset, stimulus and verdict.
// Depends on alle_pkg, the engine top level and the checker module beside it.
`timescale 1ns / 1ps

module tb_array_linked_list_engine_core;
    import alle_pkg::*;

    localparam int CAPACITY = DEPTH - 2;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int len_est;
    int target_len;
    int hold;

    array_linked_list_engine_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    array_linked_list_engine_core_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
    end

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one operation and returns after its transfer; tracks the list length.
    task automatic issue(input kind_t k, input int pos, input logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, POS_W'(pos)};
        s_tuser <= k;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (k == KIND_INSERT && pos >= 1 && pos <= len_est + 1 && len_est < CAPACITY) begin
            len_est++;
        end else if (k == KIND_DELETE && pos >= 1 && pos <= len_est) begin
            len_est--;
        end
    endtask

    // Random operations that drift the length toward a moving target, with some noise.
    task automatic random_ops(input int n_items, input bit start_full);
        int    n;
        int    roll;
        kind_t k;
        bit    grow;
        int    pos;
        target_len = start_full ? CAPACITY : target_len;
        for (n = 0; n < n_items; n++) begin
            if (len_est == target_len) begin
                if (hold == 0) begin
                    roll = $urandom_range(9);
                    if (roll < 3) begin
                        target_len = 0;
                    end else if (roll < 8) begin
                        target_len = $urandom_range(40, 1);
                    end else begin
                        target_len = CAPACITY;
                    end
                    hold = $urandom_range(12, 4);
                end else begin
                    hold--;
                end
            end
            roll = $urandom_range(99);
            if (roll < 12) begin
                k = kind_t'($urandom_range(1));
                pos = $urandom_range(255);
            end else begin
                if (target_len > len_est) begin
                    grow = 1'b1;
                end else if (target_len < len_est) begin
                    grow = 1'b0;
                end else begin
                    grow = $urandom_range(1);
                end
                if ($urandom_range(99) < 20) begin
                    grow = !grow;
                end
                if (grow) begin
                    k = KIND_INSERT;
                    pos = $urandom_range(len_est + 1, 1);
                end else begin
                    k = KIND_DELETE;
                    pos = (len_est == 0) ? $urandom_range(3) : $urandom_range(len_est, 1);
                end
            end
            issue(k, pos, $urandom);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_INSERT;
        send_idle_pct = 10;
        recv_idle_pct = 48;
        len_est = 0;
        target_len = 0;
        hold = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: range errors on an empty list, insert at front, middle and end,
        // value extremes, deletes at every place, and a delete value that must be ignored.
        issue(KIND_INSERT, 0, 32'h0000_0000);
        issue(KIND_DELETE, 1, 32'h0000_0000);
        issue(KIND_DELETE, 0, 32'hffff_ffff);
        issue(KIND_INSERT, 2, 32'h1234_5678);
        issue(KIND_INSERT, 1, 32'h7fff_ffff);
        issue(KIND_INSERT, 2, 32'h8000_0000);
        issue(KIND_INSERT, 1, 32'h0000_0000);
        issue(KIND_INSERT, 2, 32'hffff_ffff);
        issue(KIND_INSERT, 255, 32'h0000_0001);
        issue(KIND_DELETE, 5, 32'h0000_0000);
        issue(KIND_DELETE, 0, 32'h5a5a_5a5a);
        issue(KIND_DELETE, 4, 32'hdead_beef);
        issue(KIND_DELETE, 2, 32'h0000_0000);
        issue(KIND_DELETE, 1, 32'h0000_0000);
        issue(KIND_DELETE, 1, 32'hffff_ffff);
        issue(KIND_DELETE, 1, 32'h0000_0000);
        issue(KIND_INSERT, 1, 32'h5555_5555);
        issue(KIND_INSERT, 2, 32'haaaa_aaaa);
        issue(KIND_DELETE, 255, 32'h0000_0000);
        issue(KIND_INSERT, 128, 32'h0000_0000);
        issue(KIND_INSERT, 3, 32'h8000_0001);
        issue(KIND_DELETE, 3, 32'h0000_0000);
        issue(KIND_DELETE, 2, 32'h0000_0000);
        issue(KIND_DELETE, 1, 32'h0000_0000);

        random_ops(360, 1'b0);
        send_idle_pct <= 48;
        recv_idle_pct <= 10;
        // The second phase starts by filling the store so that full-store errors occur.
        random_ops(360, 1'b1);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        random_ops(360, 1'b0);

        s_tvalid <= 1'b0;
        // The count of expected results is a registered output of the checker and lags the last transfer.
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("array_linked_list_engine_core: match");
        end else begin
            $display("array_linked_list_engine_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("array_linked_list_engine_core: mismatch");
        $finish;
    end

endmodule
